@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the tag store lookup RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cacl_pkg.sv @@
// Shared constants, outcome codes, types and width helpers for the
// column-associative cache lookup. No dependencies.
package cacl_pkg;

  localparam int IN_ADDR_W = 32;
  localparam int CNT_W     = 32;
  localparam int OUTCOME_W = 2;

  localparam int DEF_ADDR_BITS   = 32;
  localparam int DEF_OFFSET_BITS = 5;
  localparam int DEF_NUM_SETS    = 256;

  localparam logic [OUTCOME_W-1:0] OC_HIT_DIRECT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OC_HIT_SWAP     = 2'd1;
  localparam logic [OUTCOME_W-1:0] OC_MISS_REPLACE = 2'd2;
  localparam logic [OUTCOME_W-1:0] OC_MISS_REHASH  = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [OUTCOME_W-1:0] outcome;
  } res_t;

  // Index width is floor(log2(num_sets)).
  function automatic int idx_width(input int num_sets);
    return $clog2(num_sets + 1) - 1;
  endfunction

  // Stored key: block address above the index, plus the top index bit.
  function automatic int key_width(input int addr_bits, input int offset_bits,
                                   input int num_sets);
    int aw;
    int kw;
    aw = (addr_bits < IN_ADDR_W) ? addr_bits : IN_ADDR_W;
    kw = aw - offset_bits - idx_width(num_sets) + 1;
    return (kw > 1) ? kw : 1;
  endfunction

endpackage

@@ hw/rtl/cacl_if.sv @@
// Valid/ready channel interfaces for the lookup requests and results.
// Depends on cacl_pkg for the payload widths.
interface cacl_in_if;
  import cacl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IN_ADDR_W-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface cacl_out_if;
  import cacl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic                 is_hit;
  logic [CNT_W-1:0]     hits_so_far;
  logic [CNT_W-1:0]     misses_so_far;
  modport source (output valid, output outcome, output is_hit, output hits_so_far,
                  output misses_so_far, input ready);
  modport sink (input valid, input outcome, input is_hit, input hits_so_far,
                input misses_so_far, output ready);
endinterface

@@ hw/rtl/cacl_tag_ram.sv @@
// Tag memory: two registered read ports and one write port.
// Standalone; widths come from the parameters.
module cacl_tag_ram #(
  parameter int IDX_W  = 8,
  parameter int DATA_W = 22
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  rd_a_addr,
  input  logic [IDX_W-1:0]  rd_b_addr,
  output logic [DATA_W-1:0] rd_a_data,
  output logic [DATA_W-1:0] rd_b_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 1 << IDX_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

@@ hw/rtl/cacl_probe.sv @@
// Probe sequencer: clears the tag memory after reset, reads both slots,
// decides the outcome and writes the entries back. Depends on cacl_pkg.
`include "assert_macros.svh"

module cacl_probe #(
  parameter int ADDR_BITS   = cacl_pkg::DEF_ADDR_BITS,
  parameter int OFFSET_BITS = cacl_pkg::DEF_OFFSET_BITS,
  parameter int IDX_W       = cacl_pkg::idx_width(cacl_pkg::DEF_NUM_SETS),
  parameter int KEY_W       = cacl_pkg::key_width(cacl_pkg::DEF_ADDR_BITS,
                                                  cacl_pkg::DEF_OFFSET_BITS,
                                                  cacl_pkg::DEF_NUM_SETS)
) (
  input  logic               clk,
  input  logic               rst_n,
  cacl_in_if.sink            in_ch,
  output logic [IDX_W-1:0]   rd_d_addr,
  output logic [IDX_W-1:0]   rd_f_addr,
  input  logic [KEY_W+1:0]   rd_d_data,
  input  logic [KEY_W+1:0]   rd_f_data,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [KEY_W+1:0]   wr_data,
  output cacl_pkg::res_t     res,
  input  logic               res_ready
);

  import cacl_pkg::*;

  localparam int AW    = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
  localparam int BLK_W = AW - OFFSET_BITS;
  localparam int EXT_W = BLK_W + IDX_W;
  localparam int ENT_W = KEY_W + 2;
  localparam logic [IDX_W-1:0] TOP = {1'b1, {(IDX_W-1){1'b0}}};

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_WRF   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [KEY_W-1:0]     key_r;
  logic [ENT_W-1:0]     old_r;
  logic [EXT_W-1:0]     blk_ext, blk_shift;
  logic [IDX_W-1:0]     in_idx;
  logic [KEY_W-1:0]     in_key;
  logic                 d_valid, d_rehash, f_valid;
  logic [KEY_W-1:0]     d_key, f_key;
  logic                 d_hit, f_hit;
  logic [OUTCOME_W-1:0] outcome;
  logic                 accept, advance;

  assign blk_ext   = EXT_W'(in_ch.address[AW-1:OFFSET_BITS]);
  assign blk_shift = blk_ext >> (IDX_W - 1);
  assign in_idx    = blk_ext[IDX_W-1:0];
  assign in_key    = blk_shift[KEY_W-1:0];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign rd_d_addr = (state_r == ST_IDLE) ? in_idx : idx_r;
  assign rd_f_addr = rd_d_addr ^ TOP;

  assign d_valid  = rd_d_data[ENT_W-1];
  assign d_rehash = rd_d_data[ENT_W-2];
  assign d_key    = rd_d_data[KEY_W-1:0];
  assign f_valid  = rd_f_data[ENT_W-1];
  assign f_key    = rd_f_data[KEY_W-1:0];
  assign d_hit    = d_valid && (d_key == key_r);
  assign f_hit    = f_valid && (f_key == key_r);

  always_comb begin
    if (d_hit) begin
      outcome = OC_HIT_DIRECT;
    end else if (d_rehash) begin
      outcome = OC_MISS_REPLACE;
    end else if (f_hit) begin
      outcome = OC_HIT_SWAP;
    end else begin
      outcome = OC_MISS_REHASH;
    end
  end

  assign res.valid   = (state_r == ST_EVAL);
  assign res.outcome = outcome;
  assign advance     = (state_r == ST_EVAL) && res_ready;

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = {1'b1, 1'b0, key_r};
    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = {1'b0, 1'b1, {KEY_W{1'b0}}};
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == {IDX_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (res_ready) begin
          wr_en = (outcome != OC_HIT_DIRECT);
          if ((outcome == OC_HIT_SWAP) || (outcome == OC_MISS_REHASH)) begin
            state_nxt = ST_WRF;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WRF: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r ^ TOP;
        wr_data   = {old_r[ENT_W-1], 1'b1, old_r[KEY_W-1:0]};
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_idx;
      key_r <= in_key;
    end
    if (advance) begin
      old_r <= rd_d_data;
    end
  end

  `ASSERT_NEXT(a_clear_ends, (state_r == ST_CLEAR) && (clr_idx_r == {IDX_W{1'b1}}), state_r == ST_IDLE, "clearing pass did not hand over to idle")
  `ASSERT_IMPLIES(a_direct_hit_no_write, (state_r == ST_EVAL) && d_hit, !wr_en, "first-probe hit modified the tag memory")

endmodule

@@ hw/rtl/cacl_stats.sv @@
// Saturating hit and miss counters and the result output register.
// Depends on cacl_pkg and the result channel interface.
`include "assert_macros.svh"

module cacl_stats (
  input  logic           clk,
  input  logic           rst_n,
  input  cacl_pkg::res_t res,
  output logic           res_ready,
  cacl_out_if.source     out_ch
);

  import cacl_pkg::*;

  logic [CNT_W-1:0]     hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]     miss_cnt_r, miss_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0] outcome_r;
  logic                 is_hit_r, is_hit_nxt;
  logic                 load;

  assign res_ready  = !out_valid_r || out_ch.ready;
  assign load       = res.valid && res_ready;
  assign is_hit_nxt = (res.outcome == OC_HIT_DIRECT) || (res.outcome == OC_HIT_SWAP);

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (load && is_hit_nxt && (hit_cnt_r != {CNT_W{1'b1}})) begin
      hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end
    if (load && !is_hit_nxt && (miss_cnt_r != {CNT_W{1'b1}})) begin
      miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      outcome_r <= res.outcome;
      is_hit_r  <= is_hit_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.outcome       = outcome_r;
  assign out_ch.is_hit        = is_hit_r;
  assign out_ch.hits_so_far   = hit_cnt_r;
  assign out_ch.misses_so_far = miss_cnt_r;

  `ASSERT_NEXT(a_hits_hold, !(load && is_hit_nxt), $stable(hit_cnt_r), "hit count moved without a hit")
  `ASSERT_NEXT(a_misses_hold, !(load && !is_hit_nxt), $stable(miss_cnt_r), "miss count moved without a miss")

endmodule

@@ hw/rtl/column_associative_cache_lookup.sv @@
// Top level of the column-associative cache tag store lookup.
// Depends on cacl_pkg, cacl_if, cacl_tag_ram, cacl_probe and cacl_stats.
//
//   Channel  Direction  Payload
//   in_ch    in         address
//   out_ch   out        outcome, is_hit, hits_so_far, misses_so_far
//
// After reset the tag memory is cleared one entry a cycle, over all
// 2**floor(log2(NUM_SETS)) entries (256 by default), while no request is accepted.
// One request at a time: it is accepted in idle and evaluated on the registered tag
// reads; a first-probe hit or a direct replace then returns to idle, while a swap or a
// rehash miss first writes the other slot, as the tag memory has a single write port.
// A result waits in the output register; the next request is accepted meanwhile
// and stalls before its outcome is issued until that register is free.
module column_associative_cache_lookup #(
  parameter int ADDR_BITS   = cacl_pkg::DEF_ADDR_BITS,
  parameter int OFFSET_BITS = cacl_pkg::DEF_OFFSET_BITS,
  parameter int NUM_SETS    = cacl_pkg::DEF_NUM_SETS
) (
  input  logic       clk,
  input  logic       rst_n,
  cacl_in_if.sink    in_ch,
  cacl_out_if.source out_ch
);

  import cacl_pkg::*;

  localparam int IDX_W = idx_width(NUM_SETS);
  localparam int KEY_W = key_width(ADDR_BITS, OFFSET_BITS, NUM_SETS);
  localparam int ENT_W = KEY_W + 2;

  logic [IDX_W-1:0] rd_d_addr, rd_f_addr, wr_addr;
  logic [ENT_W-1:0] rd_d_data, rd_f_data, wr_data;
  logic             wr_en;
  res_t             res;
  logic             res_ready;

  cacl_tag_ram #(
    .IDX_W  (IDX_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk       (clk),
    .rd_a_addr (rd_d_addr),
    .rd_b_addr (rd_f_addr),
    .rd_a_data (rd_d_data),
    .rd_b_data (rd_f_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  cacl_probe #(
    .ADDR_BITS   (ADDR_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .IDX_W       (IDX_W),
    .KEY_W       (KEY_W)
  ) u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rd_d_addr (rd_d_addr),
    .rd_f_addr (rd_f_addr),
    .rd_d_data (rd_d_data),
    .rd_f_data (rd_f_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res       (res),
    .res_ready (res_ready)
  );

  cacl_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule
